[src/flca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flca_pkg
// Shared codes, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package flca_pkg;

	localparam int OP_W     = 3;
	localparam int POS_W    = 31;
	localparam int ST_W     = 2;
	localparam int IDX_W    = 6;
	localparam int AID_W    = 16;
	localparam int TOL_W    = 10;
	localparam int MIN_W    = 7;
	localparam int SCORE_W  = 6;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 10;

	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND_A = 3'd1;
	localparam logic [OP_W-1:0] OP_APPEND_B = 3'd2;
	localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
	localparam logic [OP_W-1:0] OP_FETCH   = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_MAP_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_ALIGN = 2'd2;

	localparam logic [CFG_IX_W-1:0] CFG_TOLERANCE = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_MIN_SCORE = 2'd1;

	localparam logic [TOL_W-1:0]   TOL_RESET   = 10'd100;
	localparam logic [MIN_W-1:0]   MIN_RESET   = 7'd2;
	localparam logic [SCORE_W-1:0] SCORE_MAX   = 6'd63;
	localparam logic [11:0]        PERMILLE    = 12'd1000;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic cmp_rd;
		logic cmp_dif;
		logic cmp_m1;
		logic cmp_m2;
		logic cmp_wr;
		logic cmp_zero;
		logic sweep_init;
		logic scan_init;
		logic scan_rd;
		logic scan_dec;
		logic stp_rd;
		logic stp_eval;
		logic resp_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_region;
		logic sweep_last;
		logic scan_empty;
		logic scan_last;
		logic scan_hit;
		logic path_active;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[src/flca_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flca_ctrl
// Sequencer: item decode, matrix sweep, max scan, path step, response.
// ----------------------------------------------------------------------------
module flca_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [flca_pkg::OP_W-1:0]   op,
	input  wire flca_pkg::sts_t              sts,
	output flca_pkg::cmd_t                   cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CRD  = 4'd1;
	localparam logic [3:0] S_CDIF = 4'd2;
	localparam logic [3:0] S_CM1  = 4'd3;
	localparam logic [3:0] S_CM2  = 4'd4;
	localparam logic [3:0] S_CWR  = 4'd5;
	localparam logic [3:0] S_SRD  = 4'd6;
	localparam logic [3:0] S_SEND = 4'd7;
	localparam logic [3:0] S_SDEC = 4'd8;
	localparam logic [3:0] S_PRD  = 4'd9;
	localparam logic [3:0] S_PEV  = 4'd10;
	localparam logic [3:0] S_RESP = 4'd11;

	logic [3:0] state_q, state_d;
	logic       init_q;     // reset clearing sweep in progress

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (op)
						flca_pkg::OP_COMPUTE: begin
							cmd.sweep_init = 1'b1;
							state_d        = S_CRD;
						end
						flca_pkg::OP_FETCH: begin
							if (sts.path_active) begin
								state_d = S_PRD;
							end else begin
								cmd.scan_init = 1'b1;
								state_d       = sts.scan_empty ? S_SDEC : S_SRD;
							end
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_CRD: begin
				if (sts.in_region) begin
					cmd.cmp_rd = 1'b1;
					state_d    = S_CDIF;
				end else begin
					cmd.cmp_zero = 1'b1;
					if (sts.sweep_last) begin
						state_d = init_q ? S_IDLE : S_RESP;
					end
				end
			end
			S_CDIF: begin
				cmd.cmp_dif = 1'b1;
				state_d     = S_CM1;
			end
			S_CM1: begin
				cmd.cmp_m1 = 1'b1;
				state_d    = S_CM2;
			end
			S_CM2: begin
				cmd.cmp_m2 = 1'b1;
				state_d    = S_CWR;
			end
			S_CWR: begin
				cmd.cmp_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = init_q ? S_IDLE : S_RESP;
				end else begin
					state_d = S_CRD;
				end
			end
			S_SRD: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SEND;
				end
			end
			S_SEND: state_d = S_SDEC;
			S_SDEC: begin
				cmd.scan_dec = 1'b1;
				state_d      = sts.scan_hit ? S_PRD : S_RESP;
			end
			S_PRD: begin
				cmd.stp_rd = 1'b1;
				state_d    = S_PEV;
			end
			S_PEV: begin
				cmd.stp_eval = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CRD;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q != state_d && state_d == S_IDLE) begin
				init_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[src/flca_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flca_dp
// Datapath: position and matrix memories, tolerance arithmetic, scan, path.
// ----------------------------------------------------------------------------
module flca_dp #(
	parameter int MAX_NICKS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire flca_pkg::cmd_t                  cmd,
	output flca_pkg::sts_t                       sts,
	input  wire logic [flca_pkg::OP_W-1:0]       op,
	input  wire logic [flca_pkg::POS_W-1:0]      position,
	input  wire logic                            cfg_valid,
	input  wire logic [flca_pkg::CFG_IX_W-1:0]   cfg_index,
	input  wire logic [flca_pkg::CFG_D_W-1:0]    cfg_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [flca_pkg::ST_W-1:0]            status,
	output logic                                 pair_valid,
	output logic [flca_pkg::IDX_W-1:0]           index_a,
	output logic [flca_pkg::IDX_W-1:0]           index_b,
	output logic                                 path_end,
	output logic [flca_pkg::AID_W-1:0]           alignment_id
);

	localparam int IW    = $clog2(MAX_NICKS);
	localparam int CW    = $clog2(MAX_NICKS + 1);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = flca_pkg::SCORE_W;
	localparam int PW    = flca_pkg::POS_W;
	localparam logic [IW-1:0] LAST_IX = IW'(MAX_NICKS - 1);

	// memories
	logic [PW-1:0] pos_a_mem [MAX_NICKS];
	logic [PW-1:0] pos_b_mem [MAX_NICKS];
	logic [SW:0]   mat_mem   [DEPTH];   // {step, score}

	// control state
	logic [CW-1:0] count_a_q, count_b_q;
	logic [IW-1:0] si_q, sj_q, cur_a_q, cur_b_q;
	logic          path_active_q;
	logic [flca_pkg::AID_W-1:0] align_cnt_q;
	logic [flca_pkg::TOL_W-1:0] tol_q;
	logic [flca_pkg::MIN_W-1:0] min_q;
	logic          rdv_s1, any_q, out_valid_q;

	// payload
	logic [PW-1:0] ra0_s1, ra1_s1, rb0_s1, rb1_s1;
	logic [SW:0]   mat_rd_q;
	logic [IW-1:0] sci_s1, scj_s1, bi_q, bj_q;
	logic [SW-1:0] best_q;
	logic signed [31:0] fa_s2, fb_s2, lo_s2;
	logic [32:0]        absd_s2;
	logic signed [47:0] p1_s3, q1_s3, p2_s4, q2_s4;
	logic               skip1_s4;
	logic [flca_pkg::ST_W-1:0] res_status_q;
	logic               res_valid_q, res_end_q;
	logic [IW-1:0]      res_ia_q, res_ib_q;

	logic signed [31:0] fa_c, fb_c;
	logic signed [32:0] d_c;
	logic [11:0]        tp_c;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [SW:0]        wr_data;
	logic               wr_en, cell_ok;
	logic [SW-1:0]      sat_score;

	function automatic logic [flca_pkg::IDX_W-1:0] IDX_CAST(input logic [IW-1:0] v);
		return flca_pkg::IDX_W'(v);
	endfunction

	always_comb begin
		sts.in_region   = (si_q >= IW'(2)) && (CW'(si_q) < count_a_q) &&
		                  (sj_q >= IW'(2)) && (CW'(sj_q) < count_b_q);
		sts.sweep_last  = (si_q == LAST_IX) && (sj_q == LAST_IX);
		sts.scan_empty  = (count_a_q == '0) || (count_b_q == '0);
		sts.scan_last   = (CW'(si_q) + CW'(1) == count_a_q) &&
		                  (CW'(sj_q) + CW'(1) == count_b_q);
		sts.scan_hit    = any_q && ({1'b0, best_q} >= min_q);
		sts.path_active = path_active_q;
		sts.out_free    = !out_valid_q || out_ready;
	end

	// fragment arithmetic
	assign fa_c = $signed({1'b0, ra0_s1}) - $signed({1'b0, ra1_s1});
	assign fb_c = $signed({1'b0, rb0_s1}) - $signed({1'b0, rb1_s1});
	assign d_c  = 33'(fa_c) - 33'(fb_c);
	assign tp_c = flca_pkg::PERMILLE + 12'(tol_q);

	assign sat_score = (mat_rd_q[SW-1:0] == flca_pkg::SCORE_MAX) ?
	                   flca_pkg::SCORE_MAX : mat_rd_q[SW-1:0] + SW'(1);
	assign cell_ok   = !skip1_s4 && !(q2_s4 >= p2_s4);

	always_comb begin
		rd_addr = {sj_q, si_q};
		if (cmd.cmp_rd) begin
			rd_addr = {sj_q - IW'(1), si_q - IW'(1)};
		end else if (cmd.stp_rd) begin
			rd_addr = {cur_b_q, cur_a_q};
		end
		wr_en   = 1'b0;
		wr_addr = {sj_q, si_q};
		wr_data = '0;
		if (cmd.cmp_zero) begin
			wr_en = 1'b1;
		end else if (cmd.cmp_wr) begin
			wr_en   = 1'b1;
			wr_data = cell_ok ? {1'b1, sat_score} : '0;
		end else if (cmd.stp_eval && mat_rd_q[SW] && cur_a_q != '0 && cur_b_q != '0) begin
			wr_en   = 1'b1;
			wr_addr = {cur_b_q, cur_a_q};
			wr_data = {mat_rd_q[SW], {SW{1'b0}}};
		end
	end

	// memories; read data held until the next read command
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_mem[wr_addr] <= wr_data;
		end
		if (cmd.cmp_rd || cmd.scan_rd || cmd.stp_rd) begin
			mat_rd_q <= mat_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && op == flca_pkg::OP_APPEND_A && count_a_q < CW'(MAX_NICKS)) begin
			pos_a_mem[count_a_q[IW-1:0]] <= position;
		end
		if (cmd.accept && op == flca_pkg::OP_APPEND_B && count_b_q < CW'(MAX_NICKS)) begin
			pos_b_mem[count_b_q[IW-1:0]] <= position;
		end
		ra0_s1 <= pos_a_mem[si_q];
		ra1_s1 <= pos_a_mem[si_q - IW'(1)];
		rb0_s1 <= pos_b_mem[sj_q];
		rb1_s1 <= pos_b_mem[sj_q - IW'(1)];
	end

	// arithmetic pipeline, one product pair per step
	always_ff @(posedge clk) begin
		if (cmd.cmp_dif) begin
			fa_s2   <= fa_c;
			fb_s2   <= fb_c;
			absd_s2 <= d_c[32] ? 33'(-d_c) : 33'(d_c);
			lo_s2   <= (fa_c < fb_c) ? fa_c : fb_c;
		end
		if (cmd.cmp_m1) begin
			p1_s3 <= 48'(fb_s2) * 48'($signed({1'b0, tp_c}));
			q1_s3 <= 48'(fa_s2) * 48'($signed({1'b0, flca_pkg::PERMILLE}));
		end
		if (cmd.cmp_m2) begin
			skip1_s4 <= q1_s3 > p1_s3;
			p2_s4    <= 48'(lo_s2) * 48'($signed({1'b0, tol_q}));
			q2_s4    <= 48'($signed({1'b0, absd_s2})) *
			            48'($signed({1'b0, flca_pkg::PERMILLE}));
		end
		sci_s1 <= si_q;
		scj_s1 <= sj_q;
		if (cmd.scan_init) begin
			best_q <= '0;
		end else if (rdv_s1 && (!any_q || mat_rd_q[SW-1:0] > best_q)) begin
			best_q <= mat_rd_q[SW-1:0];
			bi_q   <= sci_s1;
			bj_q   <= scj_s1;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_status_q <= ((op == flca_pkg::OP_APPEND_A && count_a_q >= CW'(MAX_NICKS)) ||
			                 (op == flca_pkg::OP_APPEND_B && count_b_q >= CW'(MAX_NICKS))) ?
			                flca_pkg::ST_MAP_FULL : flca_pkg::ST_OK;
			res_valid_q  <= 1'b0;
			res_end_q    <= 1'b0;
			res_ia_q     <= '0;
			res_ib_q     <= '0;
		end
		if (cmd.scan_dec && !sts.scan_hit) begin
			res_status_q <= flca_pkg::ST_NO_ALIGN;
		end
		if (cmd.stp_eval) begin
			res_valid_q <= 1'b1;
			res_ia_q    <= cur_a_q;
			res_ib_q    <= cur_b_q;
			res_end_q   <= !mat_rd_q[SW] || cur_a_q == '0 || cur_b_q == '0;
		end
		if (cmd.resp_load) begin
			status       <= res_status_q;
			pair_valid   <= res_valid_q;
			index_a      <= IDX_CAST(res_ia_q);
			index_b      <= IDX_CAST(res_ib_q);
			path_end     <= res_end_q;
			alignment_id <= align_cnt_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q     <= '0;
			count_b_q     <= '0;
			si_q          <= '0;
			sj_q          <= '0;
			cur_a_q       <= '0;
			cur_b_q       <= '0;
			path_active_q <= 1'b0;
			align_cnt_q   <= '0;
			tol_q         <= flca_pkg::TOL_RESET;
			min_q         <= flca_pkg::MIN_RESET;
			rdv_s1        <= 1'b0;
			any_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == flca_pkg::CFG_TOLERANCE) begin
				tol_q <= cfg_data[flca_pkg::TOL_W-1:0];
			end
			if (cfg_valid && cfg_index == flca_pkg::CFG_MIN_SCORE) begin
				min_q <= cfg_data[flca_pkg::MIN_W-1:0];
			end
			if (cmd.accept) begin
				unique case (op)
					flca_pkg::OP_CLEAR: begin
						count_a_q     <= '0;
						count_b_q     <= '0;
						path_active_q <= 1'b0;
					end
					flca_pkg::OP_APPEND_A: begin
						if (count_a_q < CW'(MAX_NICKS)) count_a_q <= count_a_q + CW'(1);
					end
					flca_pkg::OP_APPEND_B: begin
						if (count_b_q < CW'(MAX_NICKS)) count_b_q <= count_b_q + CW'(1);
					end
					flca_pkg::OP_COMPUTE: path_active_q <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.sweep_init || cmd.scan_init) begin
				si_q <= '0;
				sj_q <= '0;
			end else if (cmd.cmp_zero || cmd.cmp_wr) begin
				if (si_q == LAST_IX) begin
					si_q <= '0;
					sj_q <= sj_q + IW'(1);
				end else begin
					si_q <= si_q + IW'(1);
				end
			end else if (cmd.scan_rd) begin
				if (CW'(si_q) + CW'(1) == count_a_q) begin
					si_q <= '0;
					sj_q <= sj_q + IW'(1);
				end else begin
					si_q <= si_q + IW'(1);
				end
			end
			rdv_s1 <= cmd.scan_rd;
			if (cmd.scan_init) begin
				any_q <= 1'b0;
			end else if (rdv_s1) begin
				any_q <= 1'b1;
			end
			if (cmd.scan_dec && sts.scan_hit) begin
				cur_a_q       <= bi_q;
				cur_b_q       <= bj_q;
				path_active_q <= 1'b1;
				align_cnt_q   <= align_cnt_q + flca_pkg::AID_W'(1);
			end
			if (cmd.stp_eval) begin
				if (!mat_rd_q[SW] || cur_a_q == '0 || cur_b_q == '0) begin
					path_active_q <= 1'b0;
				end else begin
					cur_a_q <= cur_a_q - IW'(1);
					cur_b_q <= cur_b_q - IW'(1);
				end
			end
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[src/fragment_length_chain_aligner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_length_chain_aligner
// Optical-map fragment chain aligner: two nick maps, score matrix, path walk.
// ----------------------------------------------------------------------------
//  channel  handshake               word
//  in       in_valid / in_ready     op, position
//  out      out_valid / out_ready   status, pair_valid, index_a, index_b,
//                                   path_end, alignment_id
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Clear, append and unknown ops go to the response state; a fetch on an active
//   path reads and evaluates one path step; a fetch that starts a scan reads
//   all count_a*count_b cells, decides and, if a chain aligns, takes the first
//   path step. Compute sweeps MAX_NICKS^2 cells in row-major order, zeroing
//   those outside the scored region and taking each scored cell through read,
//   difference, products and write, then loads. in_ready returns the cycle
//   after the result loads. After reset a clearing sweep of MAX_NICKS^2 cells
//   runs before in_ready. A result waits in the output register; a stalled
//   out side holds the block in its response state, cfg is always ready.
// ----------------------------------------------------------------------------
module fragment_length_chain_aligner #(
	parameter int MAX_NICKS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [flca_pkg::OP_W-1:0]       op,
	input  wire logic [flca_pkg::POS_W-1:0]      position,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [flca_pkg::ST_W-1:0]            status,
	output logic                                 pair_valid,
	output logic [flca_pkg::IDX_W-1:0]           index_a,
	output logic [flca_pkg::IDX_W-1:0]           index_b,
	output logic                                 path_end,
	output logic [flca_pkg::AID_W-1:0]           alignment_id,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [flca_pkg::CFG_IX_W-1:0]   cfg_index,
	input  wire logic [flca_pkg::CFG_D_W-1:0]    cfg_data
);

	flca_pkg::cmd_t cmd;
	flca_pkg::sts_t sts;

	// register writes never stall
	assign cfg_ready = 1'b1;

	flca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	flca_dp #(
		.MAX_NICKS (MAX_NICKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.position     (position),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.pair_valid   (pair_valid),
		.index_a      (index_a),
		.index_b      (index_b),
		.path_end     (path_end),
		.alignment_id (alignment_id)
	);

endmodule
`default_nettype wire

[test/flca_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flca_checker
// Watches the in, out and cfg channels of the chain aligner, keeps its own
// copy of the maps, score matrix and path cursor, and compares every result
// word with the oldest predicted one.
// ----------------------------------------------------------------------------
module flca_checker #(
	parameter int NICKS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [flca_pkg::OP_W-1:0]     op,
	input  wire logic [flca_pkg::POS_W-1:0]    position,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [flca_pkg::ST_W-1:0]     status,
	input  wire logic                          pair_valid,
	input  wire logic [flca_pkg::IDX_W-1:0]    index_a,
	input  wire logic [flca_pkg::IDX_W-1:0]    index_b,
	input  wire logic                          path_end,
	input  wire logic [flca_pkg::AID_W-1:0]    alignment_id,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [flca_pkg::CFG_IX_W-1:0] cfg_index,
	input  wire logic [flca_pkg::CFG_D_W-1:0]  cfg_data,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 words_checked
);

	typedef struct {
		logic [flca_pkg::ST_W-1:0]  status;
		logic                       pair_valid;
		logic [flca_pkg::IDX_W-1:0] index_a;
		logic [flca_pkg::IDX_W-1:0] index_b;
		logic                       path_end;
		logic [flca_pkg::AID_W-1:0] alignment_id;
	} chain_word_t;

	chain_word_t awaited_words[$];

	logic [flca_pkg::POS_W-1:0]   nick_a [NICKS];
	logic [flca_pkg::POS_W-1:0]   nick_b [NICKS];
	logic [flca_pkg::SCORE_W-1:0] chain_score [NICKS*NICKS];
	bit                           step_mark [NICKS*NICKS];
	int                           len_a, len_b;
	int                           cur_a, cur_b;
	bit                           walking;
	logic [flca_pkg::AID_W-1:0]   chain_no;
	int                           tol_pm;
	int                           min_chain;

	function automatic void score_maps();
		longint fa, fb, d, lo, t;
		int s;
		t = tol_pm;
		foreach (chain_score[k]) begin
			chain_score[k] = '0;
			step_mark[k] = 0;
		end
		for (int j = 2; j < len_b; j++) begin
			fb = longint'({1'b0, nick_b[j]}) - longint'({1'b0, nick_b[j-1]});
			for (int i = 2; i < len_a; i++) begin
				fa = longint'({1'b0, nick_a[i]}) - longint'({1'b0, nick_a[i-1]});
				d = (fa > fb) ? fa - fb : fb - fa;
				lo = (fa < fb) ? fa : fb;
				if (1000 * fa > fb * (1000 + t))
					continue;
				if (1000 * d >= lo * t)
					continue;
				s = chain_score[(j-1)*NICKS + i-1] + 1;
				if (s > flca_pkg::SCORE_MAX)
					s = flca_pkg::SCORE_MAX;
				chain_score[j*NICKS + i] = s[flca_pkg::SCORE_W-1:0];
				step_mark[j*NICKS + i] = 1;
			end
		end
	endfunction

	function automatic chain_word_t predict_word(logic [flca_pkg::OP_W-1:0] w_op,
		logic [flca_pkg::POS_W-1:0] w_pos);
		chain_word_t r;
		int best, bi, bj, idx;
		bit any;
		r = '{flca_pkg::ST_OK, 1'b0, '0, '0, 1'b0, '0};
		case (w_op)
			flca_pkg::OP_CLEAR: begin
				len_a = 0;
				len_b = 0;
				walking = 0;
			end
			flca_pkg::OP_APPEND_A: begin
				if (len_a < NICKS) nick_a[len_a++] = w_pos;
				else r.status = flca_pkg::ST_MAP_FULL;
			end
			flca_pkg::OP_APPEND_B: begin
				if (len_b < NICKS) nick_b[len_b++] = w_pos;
				else r.status = flca_pkg::ST_MAP_FULL;
			end
			flca_pkg::OP_COMPUTE: begin
				score_maps();
				walking = 0;
			end
			flca_pkg::OP_FETCH: begin
				if (!walking) begin
					any = 0;
					best = 0;
					bi = 0;
					bj = 0;
					// first maximum in row-major order wins
					for (int j = 0; j < len_b; j++)
						for (int i = 0; i < len_a; i++)
							if (!any || chain_score[j*NICKS + i] > best) begin
								best = chain_score[j*NICKS + i];
								bi = i;
								bj = j;
								any = 1;
							end
					if (!any || best < min_chain) begin
						r.status = flca_pkg::ST_NO_ALIGN;
					end else begin
						cur_a = bi;
						cur_b = bj;
						walking = 1;
						chain_no++;
					end
				end
				if (walking) begin
					idx = cur_b*NICKS + cur_a;
					r.pair_valid = 1;
					r.index_a = cur_a[flca_pkg::IDX_W-1:0];
					r.index_b = cur_b[flca_pkg::IDX_W-1:0];
					if (!step_mark[idx] || cur_a == 0 || cur_b == 0) begin
						r.path_end = 1;
						walking = 0;
					end else begin
						chain_score[idx] = '0;
						cur_a--;
						cur_b--;
					end
				end
			end
			default: ;
		endcase
		r.alignment_id = chain_no;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chain_word_t w;
		if (!arst_n) begin
			awaited_words.delete();
			foreach (chain_score[k]) begin
				chain_score[k] = '0;
				step_mark[k] = 0;
			end
			len_a = 0;
			len_b = 0;
			cur_a = 0;
			cur_b = 0;
			walking = 0;
			chain_no = '0;
			tol_pm = flca_pkg::TOL_RESET;
			min_chain = flca_pkg::MIN_RESET;
			fail_count = 0;
			words_checked = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == flca_pkg::CFG_TOLERANCE)
					tol_pm = cfg_data[flca_pkg::TOL_W-1:0];
				else if (cfg_index == flca_pkg::CFG_MIN_SCORE)
					min_chain = cfg_data[flca_pkg::MIN_W-1:0];
			end
			if (in_valid && in_ready)
				awaited_words.push_back(predict_word(op, position));
			if (out_valid && out_ready) begin
				words_checked++;
				if (awaited_words.size() == 0) begin
					$display("%0t: result word with none expected, got status %0d", $time,
						status);
					fail_count++;
				end else begin
					w = awaited_words.pop_front();
					check_field("status", w.status, status);
					check_field("pair_valid", w.pair_valid, pair_valid);
					check_field("index_a", w.index_a, index_a);
					check_field("index_b", w.index_b, index_b);
					check_field("path_end", w.path_end, path_end);
					check_field("alignment_id", w.alignment_id, alignment_id);
				end
			end
			pending = awaited_words.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives nick maps, compute and fetch words into the chain aligner with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	// op codes the block ignores
	localparam logic [flca_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [flca_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam logic [flca_pkg::CFG_IX_W-1:0] CFG_UNUSED = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [flca_pkg::OP_W-1:0]     op;
	logic [flca_pkg::POS_W-1:0]    position;
	logic                          out_valid;
	logic                          out_ready;
	logic [flca_pkg::ST_W-1:0]     status;
	logic                          pair_valid;
	logic [flca_pkg::IDX_W-1:0]    index_a;
	logic [flca_pkg::IDX_W-1:0]    index_b;
	logic                          path_end;
	logic [flca_pkg::AID_W-1:0]    alignment_id;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [flca_pkg::CFG_IX_W-1:0] cfg_index;
	logic [flca_pkg::CFG_D_W-1:0]  cfg_data;

	int fail_count, pending, words_checked;
	int words_sent;
	int settings_used;
	bit calm;      // no idling on either side while set
	bit hold_req;  // ask the output side for one long stall

	always #10 clk = ~clk;

	fragment_length_chain_aligner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .position(position),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.pair_valid(pair_valid), .index_a(index_a), .index_b(index_b),
		.path_end(path_end), .alignment_id(alignment_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	flca_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .position(position),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.pair_valid(pair_valid), .index_a(index_a), .index_b(index_b),
		.path_end(path_end), .alignment_id(alignment_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .words_checked(words_checked)
	);

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One input word. Ready is looked at on the falling edge, where it is
	// settled, so the handshake edge is known without racing the block.
	task automatic send_word(logic [flca_pkg::OP_W-1:0] w_op,
		logic [flca_pkg::POS_W-1:0] w_pos);
		int gap;
		bit took;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w_op;
		position <= w_pos;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		words_sent++;
	endtask

	// Let every expected word drain, then a short margin for the last one.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [flca_pkg::CFG_IX_W-1:0] ix,
		logic [flca_pkg::CFG_D_W-1:0] val);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(int tol, int min_sc);
		settle();
		write_reg(flca_pkg::CFG_TOLERANCE, flca_pkg::CFG_D_W'(tol));
		write_reg(flca_pkg::CFG_MIN_SCORE, flca_pkg::CFG_D_W'(min_sc));
		settings_used++;
	endtask

	// A well-formed run: clear, two maps that share a stretch of fragment
	// lengths, compute, then walk paths. Some noise is mixed in.
	task automatic run_chain_sequence(int n_a, int n_b);
		int unsigned len_list[64];
		int unsigned pa, pb, ln;
		int shift, fetches;
		send_word(flca_pkg::OP_CLEAR, flca_pkg::POS_W'($urandom));
		pa = $urandom_range(0, 1 << 29);
		foreach (len_list[k]) len_list[k] = $urandom_range(200, 3000);
		for (int k = 0; k < n_a; k++) begin
			if (k > 0) pa += len_list[k];
			// now and then a stray position, possibly going backwards
			send_word(flca_pkg::OP_APPEND_A,
				flca_pkg::POS_W'(($urandom_range(0, 11) == 0) ? $urandom : pa));
		end
		shift = $urandom_range(0, 3);
		pb = $urandom_range(0, 1 << 29);
		for (int k = 0; k < n_b; k++) begin
			if (k > 0) begin
				ln = len_list[(k + shift) % 64];
				if ($urandom_range(0, 4) == 0) ln = $urandom_range(200, 3000);
				else ln = ln + $urandom_range(0, ln / 20) - ln / 40;
				pb += ln;
			end
			send_word(flca_pkg::OP_APPEND_B,
				flca_pkg::POS_W'(($urandom_range(0, 11) == 0) ? $urandom : pb));
		end
		send_word(flca_pkg::OP_COMPUTE, flca_pkg::POS_W'($urandom));
		fetches = $urandom_range(4, 12);
		for (int k = 0; k < fetches; k++) begin
			case ($urandom_range(0, 15))
				// append while a path runs
				0: send_word(flca_pkg::OP_APPEND_A, flca_pkg::POS_W'($urandom));
				1: send_word(flca_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
					flca_pkg::POS_W'($urandom));
				default: ;
			endcase
			send_word(flca_pkg::OP_FETCH, flca_pkg::POS_W'($urandom));
		end
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		int n;
		bit held;
		out_ready = 1'b0;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				n = idle_len();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		in_valid = 1'b0;
		op = flca_pkg::OP_CLEAR;
		position = '0;
		cfg_valid = 1'b0;
		cfg_index = flca_pkg::CFG_TOLERANCE;
		cfg_data = '0;
		words_sent = 0;
		settings_used = 1;
		calm = 0;
		hold_req = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty maps, ignored ops, a clean 3-long chain, extremes
		send_word(flca_pkg::OP_FETCH, '0);
		send_word(OP_SPARE_LO, '1);
		send_word(OP_SPARE_HI, '0);
		send_word(flca_pkg::OP_APPEND_A, 31'd0);
		send_word(flca_pkg::OP_APPEND_A, 31'd1000);
		send_word(flca_pkg::OP_APPEND_A, 31'd2000);
		send_word(flca_pkg::OP_APPEND_A, 31'd3100);
		send_word(flca_pkg::OP_APPEND_A, 31'd4000);
		send_word(flca_pkg::OP_APPEND_A, 31'h7FFF_FFFF);
		send_word(flca_pkg::OP_APPEND_B, 31'd500);
		send_word(flca_pkg::OP_APPEND_B, 31'd1500);
		send_word(flca_pkg::OP_APPEND_B, 31'd2500);
		send_word(flca_pkg::OP_APPEND_B, 31'd3600);
		send_word(flca_pkg::OP_APPEND_B, 31'd4500);
		send_word(flca_pkg::OP_COMPUTE, '1);
		repeat (6) send_word(flca_pkg::OP_FETCH, '0);

		// zero minimum score: a zero maximum gives a one-pair path at (0,0)
		set_regs(100, 0);
		send_word(flca_pkg::OP_CLEAR, '0);
		send_word(flca_pkg::OP_FETCH, '0);
		send_word(flca_pkg::OP_APPEND_A, 31'd7);
		send_word(flca_pkg::OP_APPEND_B, 31'd9);
		send_word(flca_pkg::OP_FETCH, '0);
		send_word(flca_pkg::OP_FETCH, '0);
		settle();
		write_reg(CFG_UNUSED, '1);

		// full map A under a long output hold-off: appends past the end drop
		hold_req = 1;
		send_word(flca_pkg::OP_CLEAR, '0);
		for (int k = 0; k < 65; k++)
			send_word(flca_pkg::OP_APPEND_A,
				flca_pkg::POS_W'(k * 1000 + $urandom_range(0, 20)));
		for (int k = 0; k < 4; k++)
			send_word(flca_pkg::OP_APPEND_B,
				flca_pkg::POS_W'(5000 + k * 1000 + $urandom_range(0, 20)));
		send_word(flca_pkg::OP_COMPUTE, '0);
		repeat (2) send_word(flca_pkg::OP_FETCH, '0);

		// extreme settings first, then random sequences
		for (int s = 0; words_sent < 135; s++) begin
			if (s == 0) set_regs(0, 1);
			else if (s == 1) set_regs(1023, 64);
			else set_regs($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
				: $urandom_range(20, 150), $urandom_range(1, 4));
			calm = (s == 2);
			run_chain_sequence($urandom_range(2, 8), $urandom_range(2, 8));
		end
		calm = 0;

		settle();
		repeat (20) @(posedge clk);
		$display("Run covered %0d input words and %0d result words under %0d register settings.",
			words_sent, words_checked, settings_used);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#(64'd20 * 64'd3_000_000);
		$display("Timeout at %0t", $time);
		$display("Mismatches found");
		$finish;
	end

endmodule
